// ===== sv/psrc_pkg.sv =====
// Package for the PCM rate/width converter: types, constants, shared enums.
// No dependencies.
`timescale 1ns / 1ps
package psrc_pkg;
  localparam int RATE_W = 16;
  localparam int SAMPLE_W = 16;
  localparam logic [RATE_W-1:0] RATE_MIN = 16'd11025;
  localparam logic [RATE_W-1:0] RATE_MAX = 16'd48000;
  localparam logic [RATE_W-1:0] RATE_RESET = 16'd22050;
  localparam int MAX_RESULTS = 5;

  typedef enum logic [1:0] {
    CFG_IN_RATE  = 2'd0,
    CFG_OUT_RATE = 2'd1,
    CFG_IN_WIDE  = 2'd2,
    CFG_OUT_WIDE = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_DNSUM, ST_DNOUT, ST_DNWIN, ST_UPLEN, ST_UPSTEP, ST_EMIT
  } state_t;

  // division operand select
  typedef enum logic [2:0] {
    DV_WINLEN, DV_WINACC, DV_NEXTSUM, DV_SCALE, DV_UPLEN, DV_UPSTEP
  } dv_op_t;

  // rate relation of the clamped rates
  typedef enum logic [1:0] {
    MODE_EQUAL, MODE_DOWN, MODE_UP
  } mode_t;

  typedef struct packed {
    logic   load_x;
    logic   div_start;
    dv_op_t div_op;
    logic   dn_first;
    logic   dn_add;
    logic   save_sum;
    logic   up_len;
    logic   up_val;
    logic   emit;
    logic   last;
    logic   clear;
    logic   commit_rem;
    logic   commit_prev;
  } cmd_t;

  typedef struct packed {
    logic       div_busy;
    mode_t      mode;
    logic       win_empty;
    logic       win_full;
    logic       have_prev;
    logic       rem_nz;
    logic       up_more;
    logic       up_last;
    logic       out_busy;
  } stat_t;
endpackage

// ===== sv/psrc_divider.sv =====
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// Uses nothing from psrc_pkg; its widths come from its parameters.
`timescale 1ns / 1ps
module psrc_divider #(
  parameter int NW = 40,
  parameter int DW = 17
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [NW-1:0] num,
  input  logic        [DW-1:0] den,
  output logic                 busy,
  output logic signed [NW-1:0] quo,
  output logic        [DW-1:0] rem
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0] r_r, r_nxt;
  logic [DW-1:0] d_r;
  logic neg_r;
  logic [CW-1:0] cnt_r;
  logic [DW:0] trial;

  always_comb begin
    trial = {r_r[DW-1:0], q_r[NW-1]};
    if (trial >= {1'b0, d_r}) begin
      r_nxt = trial - {1'b0, d_r};
      q_nxt = {q_r[NW-2:0], 1'b1};
    end else begin
      r_nxt = trial;
      q_nxt = {q_r[NW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CW'(NW);
      neg_r <= num[NW-1];
      q_r <= num[NW-1] ? NW'(-num) : NW'(num);
      r_r <= '0;
      d_r <= den;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
      q_r <= q_nxt;
      r_r <= r_nxt;
    end
  end

  assign busy = (cnt_r != '0);
  assign quo = neg_r ? -$signed(q_r) : $signed(q_r);
  assign rem = r_r[DW-1:0];
endmodule

// ===== sv/psrc_datapath.sv =====
// Datapath: config registers, conversion state, shared divider, output register.
// Depends on psrc_pkg and psrc_divider.
`timescale 1ns / 1ps
module psrc_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  input  logic signed [15:0]    in_sample_in,
  input  psrc_pkg::cmd_t        cmd,
  output psrc_pkg::stat_t       stat,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [15:0]    out_sample_out,
  output logic                  out_last_of_run
);
  import psrc_pkg::*;
  localparam int NW = 40;

  logic [15:0] ir_raw_r, or_raw_r;
  logic iw_r, ow_r;
  logic [16:0] ir, orr;
  logic [15:0] rem_r, nrem_r;
  logic [2:0] wlen_r, wcnt_r, ui_r;
  logic signed [NW-1:0] acc_r, sum_r;
  logic signed [16:0] x_r, prev_r;
  logic havep_r;
  logic [2:0] dcnt_r;
  logic signed [NW-1:0] dnum;
  logic [16:0] dden;
  logic dbusy;
  logic signed [NW-1:0] dquo;
  logic [16:0] drem;
  logic signed [16:0] val;
  logic ov_r, olast_r;
  logic [15:0] od_r, wc;
  logic signed [35:0] wacc_p, nsum_p;
  logic signed [41:0] scale_p;
  logic signed [17:0] dx;
  logic signed [21:0] step_p;

  function automatic logic [16:0] clampr(input logic [15:0] r);
    if (r < RATE_MIN) return {1'b0, RATE_MIN};
    if (r > RATE_MAX) return {1'b0, RATE_MAX};
    return {1'b0, r};
  endfunction
  assign ir = clampr(ir_raw_r);
  assign orr = clampr(or_raw_r);

  // narrow products; the sum of a window stays well inside 24 bits
  assign wacc_p = x_r * $signed({1'b0, orr - {1'b0, rem_r}});
  assign nsum_p = x_r * $signed({2'b0, nrem_r});
  assign scale_p = $signed(sum_r[23:0]) * $signed({1'b0, orr});
  assign dx = 18'(x_r) - 18'(prev_r);
  assign step_p = $signed({1'b0, ui_r}) * dx;

  always_comb begin
    dnum = '0;
    dden = orr;
    unique case (cmd.div_op)
      DV_WINLEN:  dnum = NW'(ir) + NW'(rem_r);
      DV_WINACC:  dnum = NW'(wacc_p);
      DV_NEXTSUM: dnum = NW'(nsum_p);
      DV_SCALE: begin
        dnum = NW'(scale_p);
        dden = ir;
      end
      DV_UPLEN: begin
        dnum = NW'(orr) + NW'(rem_r);
        dden = ir;
      end
      DV_UPSTEP: begin
        dnum = NW'(step_p);
        dden = {14'd0, dcnt_r};
      end
      default: dnum = '0;
    endcase
  end

  psrc_divider #(.NW(NW), .DW(17)) u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .num(dnum), .den(dden),
    .busy(dbusy), .quo(dquo), .rem(drem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_raw_r <= RATE_RESET; or_raw_r <= RATE_RESET; iw_r <= 1'b1; ow_r <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_IN_RATE:  ir_raw_r <= cfg_data;
        CFG_OUT_RATE: or_raw_r <= cfg_data;
        CFG_IN_WIDE:  iw_r <= cfg_data[0];
        CFG_OUT_WIDE: ow_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  wire rate_wr = cfg_valid && (cfg_index == CFG_IN_RATE || cfg_index == CFG_OUT_RATE);

  always_ff @(posedge clk) begin
    if (!rst_n || rate_wr) begin
      rem_r <= '0; wlen_r <= '0; wcnt_r <= '0; acc_r <= '0; prev_r <= '0;
      havep_r <= 1'b0;
    end else begin
      if (cmd.load_x)
        x_r <= iw_r ? 17'(in_sample_in) : {9'd0, in_sample_in[7:0]};
      if (cmd.dn_add) begin
        acc_r <= acc_r + NW'(x_r);
        wcnt_r <= wcnt_r + 1'b1;
      end
      if (cmd.save_sum) begin
        // next remainder latched after DV_WINLEN-style division of ir+rem by orr
        nrem_r <= drem[15:0];
        sum_r <= acc_r;
      end
      if (cmd.up_val) sum_r <= sum_r + dquo; // add boundary share
      if (cmd.commit_rem) rem_r <= nrem_r;
      if (cmd.dn_first) begin
        // quotient is window accumulator start; length was stored in ui_r
        acc_r <= dquo;
        wlen_r <= ui_r;
        wcnt_r <= 3'd1;
      end
      if (cmd.up_len) begin
        dcnt_r <= dquo[2:0];
        wlen_r <= dquo[2:0];
        nrem_r <= drem[15:0];
        rem_r <= drem[15:0];
      end
      if (cmd.clear) ui_r <= dquo[2:0];  // latched quotient (window length)
      if (cmd.emit && stat.mode == MODE_UP) ui_r <= ui_r + 1'b1;
      if (cmd.commit_prev) begin
        prev_r <= x_r; havep_r <= 1'b1; ui_r <= '0;
      end
    end
  end

  // emitted value
  always_comb begin
    unique case (stat.mode)
      MODE_DOWN: val = dquo[16:0];
      MODE_UP:   val = prev_r + dquo[16:0];
      default:   val = x_r;
    endcase
    if (iw_r && !ow_r) wc = {8'd0, 8'(val / 256 + 128)};
    else if (!iw_r && ow_r) wc = 16'((val - 17'sd128) * 256);
    else if (!ow_r) wc = {8'd0, val[7:0]};
    else wc = val[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (cmd.emit) ov_r <= 1'b1;
    else if (!out_stall) ov_r <= 1'b0;
    if (cmd.emit) begin od_r <= wc; olast_r <= cmd.last; end
  end

  assign out_valid = ov_r;
  assign out_sample_out = od_r;
  assign out_last_of_run = olast_r;

  always_comb begin
    stat.div_busy = dbusy;
    stat.mode = (ir > orr) ? MODE_DOWN : (ir < orr) ? MODE_UP : MODE_EQUAL;
    stat.win_empty = (wlen_r == '0);
    stat.win_full = !(wcnt_r < wlen_r);
    stat.have_prev = havep_r;
    stat.rem_nz = (nrem_r != '0);
    stat.up_more = (ui_r < dcnt_r) && (ui_r < 3'(MAX_RESULTS));
    stat.up_last = !((ui_r + 3'd1 < dcnt_r) && (ui_r + 3'd1 < 3'(MAX_RESULTS)));
    stat.out_busy = ov_r && out_stall;
  end
endmodule

// ===== sv/psrc_ctrl.sv =====
// Controller FSM: sequences the divider steps for one item and the emits.
// Depends on psrc_pkg.
`timescale 1ns / 1ps
module psrc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  psrc_pkg::stat_t stat,
  output psrc_pkg::cmd_t  cmd
);
  import psrc_pkg::*;
  state_t state_r, state_nxt;
  dv_op_t op_r, op_nxt;
  logic wait_r, wait_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; op_r <= DV_WINLEN; wait_r <= 1'b0;
    end else begin
      state_r <= state_nxt; op_r <= op_nxt; wait_r <= wait_nxt;
    end
  end

  // wait_r: a division was launched last cycle; its busy is now visible
  wire div_done = !wait_r && !stat.div_busy;

  always_comb begin
    cmd = '0;
    cmd.div_op = op_r;
    state_nxt = state_r;
    op_nxt = op_r;
    wait_nxt = 1'b0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_x = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // dispatch on mode
        if (stat.mode == MODE_EQUAL) begin
          state_nxt = ST_EMIT;
        end else if (stat.mode == MODE_DOWN) begin
          if (stat.win_empty || !stat.win_full) begin
            if (stat.win_empty) begin
              op_nxt = DV_WINLEN; cmd.div_op = DV_WINLEN; cmd.div_start = 1'b1;
              wait_nxt = 1'b1; state_nxt = ST_DNWIN;
            end else begin
              cmd.dn_add = 1'b1; state_nxt = ST_IDLE;
            end
          end else begin
            cmd.div_op = DV_WINLEN; cmd.div_start = 1'b1; op_nxt = DV_WINLEN;
            wait_nxt = 1'b1; state_nxt = ST_DNSUM;
          end
        end else begin
          if (stat.have_prev) begin
            cmd.div_op = DV_UPLEN; cmd.div_start = 1'b1; op_nxt = DV_UPLEN;
            wait_nxt = 1'b1; state_nxt = ST_UPLEN;
          end else begin
            cmd.commit_prev = 1'b1; state_nxt = ST_IDLE;
          end
        end
      end
      ST_DNSUM: begin
        // op_r tracks sub-step: WINLEN -> NEXTSUM -> SCALE (NEXTSUM skipped if the new remainder is zero)
        if (div_done) begin
          if (op_r == DV_WINLEN) begin
            cmd.save_sum = 1'b1;
            op_nxt = DV_NEXTSUM; state_nxt = ST_DNOUT;
          end else if (op_r == DV_NEXTSUM) begin
            cmd.up_val = 1'b1;
            op_nxt = DV_SCALE; cmd.div_op = DV_SCALE;
            state_nxt = ST_DNOUT;
          end else begin
            if (!stat.out_busy) begin
              cmd.emit = 1'b1; cmd.last = 1'b1; cmd.commit_rem = 1'b1;
              op_nxt = DV_WINLEN; state_nxt = ST_DNOUT;
            end
          end
        end
      end
      ST_DNOUT: begin
        // launch next division of the down sequence
        if (op_r == DV_NEXTSUM) begin
          if (stat.rem_nz) begin
            cmd.div_start = 1'b1; wait_nxt = 1'b1; state_nxt = ST_DNSUM;
          end else begin
            op_nxt = DV_SCALE; cmd.div_op = DV_SCALE; cmd.div_start = 1'b1;
            wait_nxt = 1'b1; state_nxt = ST_DNSUM;
          end
        end else if (op_r == DV_SCALE) begin
          cmd.div_start = 1'b1; wait_nxt = 1'b1; state_nxt = ST_DNSUM;
        end else begin
          cmd.div_start = 1'b1; wait_nxt = 1'b1; state_nxt = ST_DNWIN;
        end
      end
      ST_DNWIN: begin
        // WINLEN quotient -> ui, then WINACC -> acc
        if (div_done) begin
          if (op_r == DV_WINLEN) begin
            cmd.clear = 1'b1;
            op_nxt = DV_WINACC; cmd.div_op = DV_WINACC; cmd.div_start = 1'b1;
            wait_nxt = 1'b1;
          end else begin
            cmd.dn_first = 1'b1; op_nxt = DV_WINLEN; state_nxt = ST_IDLE;
          end
        end
      end
      ST_UPLEN: begin
        if (div_done) begin
          cmd.up_len = 1'b1;
          op_nxt = DV_UPSTEP; state_nxt = ST_UPSTEP;
        end
      end
      ST_UPSTEP: begin
        if (!stat.up_more) begin
          cmd.commit_prev = 1'b1; state_nxt = ST_IDLE;
        end else begin
          cmd.div_start = 1'b1; wait_nxt = 1'b1; state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (div_done && !stat.out_busy) begin
          cmd.emit = 1'b1;
          if (stat.mode == MODE_EQUAL) begin
            cmd.last = 1'b1; state_nxt = ST_IDLE;
          end else begin
            cmd.last = stat.up_last; state_nxt = ST_UPSTEP;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// ===== sv/pcm_sample_rate_and_width_converter_unit.sv =====
// PCM sample rate and width converter.
// Channels: in_ (valid/stall) carries one sample per item; out_ (valid/stall)
// gives 0..5 converted samples per input item, last_of_run on the final one;
// cfg_ (valid/ready, always ready) writes input_rate, output_rate,
// input_is_wide, output_is_wide by index.
// Operation: each item is handled alone. Equal rates emit the converted sample.
// Down conversion only accumulates inside a window, runs the serial divider
// twice at the window start and four or five times at a window boundary.
// Up conversion stores the first sample; otherwise it runs the divider once
// for the run length and once per result.
// Output is registered; a stalled result holds and the block waits for it
// before emitting the next one.
// Reset (synchronous, rst_n low) restores default rates and widths and clears
// the conversion state; writing either rate register clears the state too.
// Depends on psrc_pkg, psrc_ctrl, psrc_datapath, psrc_divider.
`timescale 1ns / 1ps
module pcm_sample_rate_and_width_converter_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_sample_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample_out,
  output logic               out_last_of_run,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import psrc_pkg::*;
  cmd_t cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  psrc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .stat(stat), .cmd(cmd)
  );

  psrc_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid && cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .in_sample_in(in_sample_in),
    .cmd(cmd), .stat(stat), .out_valid(out_valid), .out_stall(out_stall),
    .out_sample_out(out_sample_out), .out_last_of_run(out_last_of_run)
  );
endmodule

// ===== sv/psrc_checker.sv =====
// Port-level checker for the converter, bound to the top level.
// Depends on pcm_sample_rate_and_width_converter_unit ports only.
`timescale 1ns / 1ps
module psrc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_sample_out,
  input logic        out_last_of_run
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample_out)
      && $stable(out_last_of_run))
    else $error("stalled result changed");
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("took a second item while busy");
endmodule

bind pcm_sample_rate_and_width_converter_unit psrc_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_sample_out(out_sample_out),
  .out_last_of_run(out_last_of_run)
);
